// ----- rtl/mwsb_pkg.sv -----
// Package for the moving-window sum band check: widths, register and class codes.
package mwsb_pkg;

  localparam int unsigned RAW_W      = 16;
  localparam int unsigned CAL_W      = 16;
  localparam int unsigned SUM_W      = 22;
  localparam int unsigned CNT_W      = 32;
  localparam int unsigned GAIN_W     = 16;
  localparam int unsigned LIMIT_W    = 22;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [SUM_W-1:0]   SUM_MAX  = {SUM_W{1'b1}};
  localparam logic [GAIN_W-1:0]  GAIN_RST = 16'd256;
  localparam logic [LIMIT_W-1:0] HIGH_RST = {LIMIT_W{1'b1}};

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CAL_GAIN   = 3'd0,
    REG_CAL_OFFSET = 3'd1,
    REG_WINDOW_LEN = 3'd2,
    REG_LOW_LIMIT  = 3'd3,
    REG_HIGH_LIMIT = 3'd4
  } cfg_reg_e;

  typedef enum logic [1:0] {
    CLASS_NORMAL = 2'd0,
    CLASS_LOW    = 2'd1,
    CLASS_HIGH   = 2'd2
  } window_class_e;

endpackage

// ----- rtl/mwsb_if.sv -----
// Handshake interfaces for the sample input, the window result output and the register port.
interface mwsb_in_if;
  import mwsb_pkg::*;
  logic             valid;
  logic             ready;
  logic [RAW_W-1:0] raw_sample;
  modport source (output valid, output raw_sample, input ready);
  modport sink (input valid, input raw_sample, output ready);
endinterface

interface mwsb_out_if;
  import mwsb_pkg::*;
  logic             valid;
  logic             ready;
  logic [CNT_W-1:0] window_index;
  logic [SUM_W-1:0] window_sum;
  logic [1:0]       window_class;
  logic [CNT_W-1:0] low_count;
  logic [CNT_W-1:0] high_count;
  modport source (output valid, output window_index, output window_sum,
                  output window_class, output low_count, output high_count, input ready);
  modport sink (input valid, input window_index, input window_sum,
                input window_class, input low_count, input high_count, output ready);
endinterface

interface mwsb_cfg_if;
  import mwsb_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ----- rtl/mwsb_cal.sv -----
// Linear calibration of one raw sample: (gain * raw) >> 8 + offset, clamped to 0..65535.
module mwsb_cal (
  input  logic [mwsb_pkg::GAIN_W-1:0] gain_i,
  input  logic signed [15:0]          offset_i,
  input  logic [mwsb_pkg::RAW_W-1:0]  raw_i,
  output logic [mwsb_pkg::CAL_W-1:0]  cal_o
);
  import mwsb_pkg::*;

  logic [GAIN_W+RAW_W-1:0] prod;
  logic [GAIN_W+RAW_W-9:0] scaled;
  logic signed [25:0]      biased;

  assign prod   = gain_i * raw_i;
  assign scaled = prod[GAIN_W+RAW_W-1:8];
  assign biased = $signed({2'b00, scaled}) + 26'(offset_i);

  always_comb begin
    if (biased < 0) begin
      cal_o = '0;
    end else if (biased > 26'sd65535) begin
      cal_o = '1;
    end else begin
      cal_o = biased[CAL_W-1:0];
    end
  end

endmodule

// ----- rtl/moving_window_sum_band_check.sv -----
// Top level of the moving-window sum band check.
// Each accepted sample is calibrated, pushed into a circular delay line of window_len entries
// and added to a running sum. Once the window is full, every sample yields one result with the
// window index, the window sum (clamped to 22 bits), its class against the low and high limits
// and saturating totals of low and high windows. One sample is taken per clock cycle unless a
// stalled output holds the pipeline; a sample passes an input stage (delay line read), a
// calibration stage (multiplier, delay line write) and the sum/classify step into the output
// register. Writing window_len restarts the window; totals are kept. Register writes are taken
// at any time but are meant for an idle block.
module moving_window_sum_band_check #(
  parameter int unsigned MAX_WINDOW = 64
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  mwsb_in_if.sink   in_i,
  mwsb_out_if.source out_o,
  mwsb_cfg_if.sink  cfg_i
);
  import mwsb_pkg::*;

  localparam int unsigned LenW   = $clog2(MAX_WINDOW + 1);
  localparam int unsigned PtrW   = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int unsigned SumW   = CAL_W + $clog2(MAX_WINDOW);
  localparam int unsigned CmpW   = (SumW > SUM_W) ? SumW : SUM_W;
  localparam int unsigned LenRst = (MAX_WINDOW < 5) ? MAX_WINDOW : 5;

  // Configuration.
  logic [GAIN_W-1:0]  gain_q;
  logic signed [15:0] offset_q;
  logic [LenW-1:0]    len_q;
  logic [LIMIT_W-1:0] low_lim_q;
  logic [LIMIT_W-1:0] high_lim_q;
  logic               restart;
  logic [LenW-1:0]    len_d;

  // Window control.
  logic [LenW-1:0] fill_q;
  logic [PtrW-1:0] wp_q;
  logic [SumW-1:0] sum_q;
  logic [CNT_W-1:0] idx_q;
  logic [CNT_W-1:0] low_tot_q;
  logic [CNT_W-1:0] high_tot_q;

  // Pipeline.
  logic             valid_a_q, valid_b_q, out_valid_q;
  logic [RAW_W-1:0] raw_a_q;
  logic [PtrW-1:0]  slot_a_q;
  logic             sub_a_q, emit_a_q, sub_b_q, emit_b_q;
  logic [CAL_W-1:0] old_rd_q, old_b_q, cal_b_q, cal_a;
  logic [CAL_W-1:0] line_mem [MAX_WINDOW];

  logic [CNT_W-1:0] out_idx_q, out_low_q, out_high_q;
  logic [SUM_W-1:0] out_sum_q;
  window_class_e    out_cls_q;

  logic in_go, a_go, a_free, b_go, b_free, out_free;
  logic sub_in, emit_in;
  logic [LenW:0]   fill_inc;
  logic [PtrW:0]   wp_inc;
  logic [SumW-1:0] sum_next;
  logic [CmpW-1:0] sum_ext;
  logic [SUM_W-1:0] sum_sat;
  window_class_e   cls;

  // Handshake chain: each stage moves on when the one after it is free or moving.
  assign out_free = !out_valid_q || out_o.ready;
  assign b_go     = valid_b_q && (!emit_b_q || out_free);
  assign b_free   = !valid_b_q || b_go;
  assign a_go     = valid_a_q && b_free;
  assign a_free   = !valid_a_q || a_go;
  assign in_i.ready = a_free;
  assign in_go    = in_i.valid && a_free;
  assign cfg_i.ready = 1'b1;

  assign restart = cfg_i.valid && (cfg_reg_e'(cfg_i.index) == REG_WINDOW_LEN);

  always_comb begin
    if (cfg_i.data[6:0] == 7'd0) begin
      len_d = LenW'(1);
    end else if (32'(cfg_i.data[6:0]) > 32'(MAX_WINDOW)) begin
      len_d = LenW'(MAX_WINDOW);
    end else begin
      len_d = LenW'(cfg_i.data[6:0]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q     <= GAIN_RST;
      offset_q   <= '0;
      len_q      <= LenW'(LenRst);
      low_lim_q  <= '0;
      high_lim_q <= HIGH_RST;
    end else if (cfg_i.valid) begin
      unique case (cfg_reg_e'(cfg_i.index))
        REG_CAL_GAIN:   gain_q     <= cfg_i.data[GAIN_W-1:0];
        REG_CAL_OFFSET: offset_q   <= $signed(cfg_i.data[15:0]);
        REG_WINDOW_LEN: len_q      <= len_d;
        REG_LOW_LIMIT:  low_lim_q  <= cfg_i.data[LIMIT_W-1:0];
        REG_HIGH_LIMIT: high_lim_q <= cfg_i.data[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  // Decisions for an incoming sample depend only on how full the window is.
  assign fill_inc = {1'b0, fill_q} + 1'b1;
  assign wp_inc   = {1'b0, wp_q} + 1'b1;
  assign sub_in   = (fill_q == len_q);
  assign emit_in  = sub_in || (fill_inc == {1'b0, len_q});

  mwsb_cal u_cal (
    .gain_i   (gain_q),
    .offset_i (offset_q),
    .raw_i    (raw_a_q),
    .cal_o    (cal_a)
  );

  // Delay line. A read that hits the entry written in the same cycle takes the new value,
  // which happens for a window of one and can also happen after a restart.
  always_ff @(posedge clk_i) begin
    if (a_go) begin
      line_mem[slot_a_q] <= cal_a;
    end
    if (in_go) begin
      old_rd_q <= (a_go && (slot_a_q == wp_q)) ? cal_a : line_mem[wp_q];
    end
  end

  // Running sum: drop the oldest sample first so the sum never exceeds a full window.
  assign sum_next = SumW'(sum_q - (sub_b_q ? SumW'(old_b_q) : SumW'(0))) + SumW'(cal_b_q);
  assign sum_ext  = CmpW'(sum_next);
  assign sum_sat  = (sum_ext > CmpW'(SUM_MAX)) ? SUM_MAX : sum_ext[SUM_W-1:0];

  always_comb begin
    if (sum_sat < low_lim_q) begin
      cls = CLASS_LOW;
    end else if (sum_sat > high_lim_q) begin
      cls = CLASS_HIGH;
    end else begin
      cls = CLASS_NORMAL;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_a_q   <= 1'b0;
      valid_b_q   <= 1'b0;
      out_valid_q <= 1'b0;
      fill_q      <= '0;
      wp_q        <= '0;
      sum_q       <= '0;
      idx_q       <= '0;
      low_tot_q   <= '0;
      high_tot_q  <= '0;
    end else begin
      if (in_go) begin
        valid_a_q <= 1'b1;
      end else if (a_go) begin
        valid_a_q <= 1'b0;
      end
      if (a_go) begin
        valid_b_q <= 1'b1;
      end else if (b_go) begin
        valid_b_q <= 1'b0;
      end
      if (b_go && emit_b_q) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end

      if (restart) begin
        fill_q <= '0;
        wp_q   <= '0;
      end else if (in_go) begin
        if (!sub_in) begin
          fill_q <= fill_inc[LenW-1:0];
        end
        wp_q <= (wp_inc >= (PtrW+1)'(len_q)) ? '0 : wp_inc[PtrW-1:0];
      end

      if (restart) begin
        sum_q <= '0;
        idx_q <= '0;
      end else if (b_go) begin
        sum_q <= sum_next;
        if (emit_b_q) begin
          idx_q <= idx_q + 1'b1;
        end
      end

      if (b_go && emit_b_q) begin
        if (cls == CLASS_LOW && low_tot_q != '1) begin
          low_tot_q <= low_tot_q + 1'b1;
        end
        if (cls == CLASS_HIGH && high_tot_q != '1) begin
          high_tot_q <= high_tot_q + 1'b1;
        end
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (in_go) begin
      raw_a_q  <= in_i.raw_sample;
      slot_a_q <= wp_q;
      sub_a_q  <= sub_in;
      emit_a_q <= emit_in;
    end
    if (a_go) begin
      cal_b_q  <= cal_a;
      old_b_q  <= old_rd_q;
      sub_b_q  <= sub_a_q;
      emit_b_q <= emit_a_q;
    end
    if (b_go && emit_b_q) begin
      out_idx_q  <= idx_q;
      out_sum_q  <= sum_sat;
      out_cls_q  <= cls;
      out_low_q  <= (cls == CLASS_LOW && low_tot_q != '1) ? low_tot_q + 1'b1 : low_tot_q;
      out_high_q <= (cls == CLASS_HIGH && high_tot_q != '1) ? high_tot_q + 1'b1 : high_tot_q;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.window_index = out_idx_q;
  assign out_o.window_sum   = out_sum_q;
  assign out_o.window_class = out_cls_q;
  assign out_o.low_count    = out_low_q;
  assign out_o.high_count   = out_high_q;

endmodule

// ----- tb/sv/mwsb_window_checker.sv -----
// Checker for the moving-window sum band check: predicts every window result and compares it.
`timescale 1ns / 1ps
module mwsb_window_checker #(
  parameter int unsigned MAX_WINDOW = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  mwsb_in_if          in_mon,
  mwsb_out_if         out_mon,
  mwsb_cfg_if         cfg_mon,
  output int unsigned pending_o,
  output int unsigned errors_o
);
  import mwsb_pkg::*;

  localparam int unsigned LEN_W = 7;

  typedef struct {
    logic [CNT_W-1:0] index;
    logic [SUM_W-1:0] sum;
    window_class_e    cls;
    logic [CNT_W-1:0] lows;
    logic [CNT_W-1:0] highs;
  } window_result_t;

  // Register copy.
  logic [GAIN_W-1:0]         gain;
  logic signed [CAL_W-1:0]   offset;
  logic [LEN_W-1:0]          len_code;
  logic [LIMIT_W-1:0]        low_lim;
  logic [LIMIT_W-1:0]        high_lim;

  // Window state.
  logic [CAL_W-1:0]  delay_line [MAX_WINDOW];
  longint unsigned   sum_acc;
  int unsigned       fill;
  int unsigned       wptr;
  logic [CNT_W-1:0]  next_index;
  logic [CNT_W-1:0]  low_total;
  logic [CNT_W-1:0]  high_total;

  window_result_t    expected_windows [$];
  int unsigned       mismatches;

  function automatic int unsigned window_span();
    if (len_code == '0) return 1;
    if (len_code > MAX_WINDOW) return MAX_WINDOW;
    return len_code;
  endfunction

  function automatic logic [CAL_W-1:0] calibrate(logic [RAW_W-1:0] raw);
    logic [31:0] prod;
    longint      scaled;
    prod   = 32'(gain) * 32'(raw);
    scaled = longint'(prod >> 8) + longint'(offset);
    if (scaled < 0) return '0;
    if (scaled > 65535) return '1;
    return scaled[CAL_W-1:0];
  endfunction

  task automatic restart_window();
    sum_acc    = 0;
    fill       = 0;
    wptr       = 0;
    next_index = '0;
  endtask

  task automatic reset_model();
    gain     = GAIN_RST;
    offset   = '0;
    len_code = LEN_W'(5);
    low_lim  = '0;
    high_lim = HIGH_RST;
    foreach (delay_line[i]) delay_line[i] = '0;
    restart_window();
    low_total  = '0;
    high_total = '0;
    expected_windows.delete();
    mismatches = 0;
  endtask

  task automatic apply_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    case (cfg_reg_e'(idx))
      REG_CAL_GAIN:   gain = data[GAIN_W-1:0];
      REG_CAL_OFFSET: offset = data[CAL_W-1:0];
      REG_WINDOW_LEN: begin
        len_code = data[LEN_W-1:0];
        restart_window();
      end
      REG_LOW_LIMIT:  low_lim = data[LIMIT_W-1:0];
      REG_HIGH_LIMIT: high_lim = data[LIMIT_W-1:0];
      default: ;
    endcase
  endtask

  task automatic predict_window(logic [RAW_W-1:0] raw);
    int unsigned      span;
    int unsigned      slot;
    logic [CAL_W-1:0] cal;
    window_result_t   r;
    span = window_span();
    slot = wptr % span;
    cal  = calibrate(raw);
    if (fill < span) begin
      fill++;
    end else begin
      sum_acc -= delay_line[slot];
    end
    delay_line[slot] = cal;
    sum_acc += cal;
    slot++;
    if (slot >= span) slot = 0;
    wptr = slot;
    // No window result until the delay line holds a full window.
    if (fill < span) return;
    r.index = next_index;
    r.sum   = (sum_acc > SUM_MAX) ? SUM_MAX : sum_acc[SUM_W-1:0];
    // The low test wins when the limits are crossed.
    if (r.sum < low_lim) begin
      r.cls = CLASS_LOW;
      if (low_total != '1) low_total++;
    end else if (r.sum > high_lim) begin
      r.cls = CLASS_HIGH;
      if (high_total != '1) high_total++;
    end else begin
      r.cls = CLASS_NORMAL;
    end
    r.lows  = low_total;
    r.highs = high_total;
    expected_windows.insert(expected_windows.size(), r);
    next_index++;
  endtask

  task automatic report_mismatch(string msg);
    mismatches++;
    $display("mismatch at %0t: %s", $realtime, msg);
  endtask

  task automatic check_window();
    window_result_t r;
    if (expected_windows.size() == 0) begin
      report_mismatch($sformatf("unexpected window result, window_index %0d",
                                out_mon.window_index));
      return;
    end
    r = expected_windows.pop_front();
    if (out_mon.window_index !== r.index)
      report_mismatch($sformatf("window %0d: window_index %0d", r.index,
                                out_mon.window_index));
    if (out_mon.window_sum !== r.sum)
      report_mismatch($sformatf("window %0d: window_sum %0d, expected %0d", r.index,
                                out_mon.window_sum, r.sum));
    if (out_mon.window_class !== r.cls)
      report_mismatch($sformatf("window %0d: window_class %0d, expected %s", r.index,
                                out_mon.window_class, r.cls.name()));
    if (out_mon.low_count !== r.lows)
      report_mismatch($sformatf("window %0d: low_count %0d, expected %0d", r.index,
                                out_mon.low_count, r.lows));
    if (out_mon.high_count !== r.highs)
      report_mismatch($sformatf("window %0d: high_count %0d, expected %0d", r.index,
                                out_mon.high_count, r.highs));
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reset_model();
    end else begin
      if (cfg_mon.valid && cfg_mon.ready) apply_register(cfg_mon.index, cfg_mon.data);
      if (out_mon.valid && out_mon.ready) check_window();
      if (in_mon.valid && in_mon.ready) predict_window(in_mon.raw_sample);
    end
    pending_o <= expected_windows.size();
    errors_o  <= mismatches;
  end

endmodule

// ----- tb/sv/tb_moving_window_sum_band_check.sv -----
// Testbench top for the moving-window sum band check: stimulus, handshake pacing and verdict.
`timescale 1ns / 1ps
module tb_moving_window_sum_band_check;
  import mwsb_pkg::*;

  localparam int unsigned MAX_WINDOW   = 64;
  localparam int unsigned LEN_W        = 7;
  localparam int unsigned SAMPLE_GOAL  = 1700;
  localparam int unsigned CALM_SAMPLES = 150;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned CYCLE_LIMIT  = 500000;
  localparam logic [CFG_IDX_W-1:0] FIRST_SPARE_INDEX = 3'd5;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  mwsb_in_if  in_if ();
  mwsb_out_if out_if ();
  mwsb_cfg_if cfg_if ();

  int unsigned pending;
  int unsigned errors;
  int unsigned cycles = 0;
  int unsigned samples_sent = 0;
  bit          gaps_on = 1'b0;
  bit          stalls_on = 1'b0;

  // Tracked settings, used to aim the limits near the expected sums and to size each phase.
  int unsigned cur_gain = 256;
  int          cur_offset = 0;
  int unsigned cur_span = 5;

  always #1 clk_i = ~clk_i;

  moving_window_sum_band_check #(
    .MAX_WINDOW(MAX_WINDOW)
  ) u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if),
    .cfg_i  (cfg_if)
  );

  mwsb_window_checker #(
    .MAX_WINDOW(MAX_WINDOW)
  ) u_checker (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_mon    (in_if),
    .out_mon   (out_if),
    .cfg_mon   (cfg_if),
    .pending_o (pending),
    .errors_o  (errors)
  );

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  // Result side: ready drops in random bursts while stalls are enabled.
  initial begin
    out_if.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (stalls_on && $urandom_range(0, 7) == 0) begin
        out_if.ready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk_i);
      end
      out_if.ready <= 1'b1;
    end
  end

  task automatic send_sample(logic [RAW_W-1:0] raw);
    if (gaps_on && $urandom_range(0, 5) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk_i);
    end
    in_if.valid      <= 1'b1;
    in_if.raw_sample <= raw;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    samples_sent++;
  endtask

  // Holds the sender until every expected window has come out.
  task automatic hold_until_drained();
    in_if.valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  // Drain and then give samples that produce no window time to leave the pipeline.
  task automatic settle();
    hold_until_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // The upper data bits beyond the register width carry random junk.
  task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] field,
                                int unsigned width);
    logic [CFG_DATA_W-1:0] mask;
    mask = (width >= CFG_DATA_W) ? '1 : ((CFG_DATA_W'(1) << width) - 1);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= (CFG_DATA_W'($urandom()) & ~mask) | (field & mask);
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
  endtask

  task automatic end_writes();
    cfg_if.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_gain(int unsigned g);
    cur_gain = g;
    write_register(REG_CAL_GAIN, CFG_DATA_W'(g), GAIN_W);
  endtask

  task automatic set_offset(int o);
    cur_offset = o;
    write_register(REG_CAL_OFFSET, CFG_DATA_W'(o), CAL_W);
  endtask

  task automatic set_length(int unsigned code);
    cur_span = (code == 0) ? 1 : (code > MAX_WINDOW) ? MAX_WINDOW : code;
    write_register(REG_WINDOW_LEN, CFG_DATA_W'(code), LEN_W);
  endtask

  task automatic set_limits(int unsigned lo, int unsigned hi);
    write_register(REG_LOW_LIMIT, CFG_DATA_W'(lo), LIMIT_W);
    write_register(REG_HIGH_LIMIT, CFG_DATA_W'(hi), LIMIT_W);
  endtask

  task automatic configure_random(bit every_reg);
    longint      est;
    longint      center;
    longint      lo;
    longint      hi;
    longint      swap;
    int unsigned pick;
    if (every_reg || $urandom_range(0, 3) != 0) begin
      case ($urandom_range(0, 3))
        0: set_gain(256);
        1: set_gain($urandom_range(0, 65535));
        2: set_gain($urandom_range(0, 600));
        default: set_gain($urandom_range(0, 1) ? 65535 : 0);
      endcase
    end
    if (every_reg || $urandom_range(0, 3) != 0) begin
      case ($urandom_range(0, 2))
        0: set_offset(0);
        1: set_offset(int'($urandom_range(0, 65535)) - 32768);
        default: set_offset(int'($urandom_range(0, 4000)) - 2000);
      endcase
    end
    // Changing the length restarts the window; otherwise it carries on across phases.
    if (every_reg || $urandom_range(0, 2) != 0) begin
      pick = $urandom_range(0, 19);
      if (pick < 12) set_length($urandom_range(1, 8));
      else if (pick < 17) set_length($urandom_range(9, MAX_WINDOW));
      else if (pick < 19) set_length($urandom_range(MAX_WINDOW + 1, 127));
      else set_length(0);
    end
    if (every_reg || $urandom_range(0, 3) != 0) begin
      est = (longint'(cur_gain) * 32768) / 256 + longint'(cur_offset);
      if (est < 0) est = 0;
      if (est > 65535) est = 65535;
      center = longint'(cur_span) * est;
      lo = center - longint'(cur_span) * $urandom_range(0, 20000);
      hi = center + longint'(cur_span) * $urandom_range(0, 20000);
      if (lo < 0) lo = 0;
      if (hi > longint'(SUM_MAX)) hi = longint'(SUM_MAX);
      case ($urandom_range(0, 9))
        0: begin
          swap = lo;
          lo   = hi;
          hi   = swap;
        end
        1: begin
          lo = 0;
          hi = longint'(SUM_MAX);
        end
        2: begin
          lo = $urandom_range(0, SUM_MAX);
          hi = $urandom_range(0, SUM_MAX);
        end
        default: ;
      endcase
      set_limits(32'(lo), 32'(hi));
    end
    if ($urandom_range(0, 5) == 0)
      write_register(FIRST_SPARE_INDEX + CFG_IDX_W'($urandom_range(0, 2)), $urandom(),
                     CFG_DATA_W);
    end_writes();
  endtask

  task automatic run_phase(bit every_reg, bit calm);
    int unsigned      count;
    int unsigned      pause_at;
    int unsigned      raw_mode;
    logic [RAW_W-1:0] base;
    logic [RAW_W-1:0] raw;
    configure_random(every_reg);
    gaps_on   = !calm && $urandom_range(0, 3) != 0;
    stalls_on = !calm && $urandom_range(0, 3) != 0;
    count     = cur_span + $urandom_range(4, 60);
    pause_at  = ($urandom_range(0, 3) == 0) ? $urandom_range(1, count) : 0;
    raw_mode  = $urandom_range(0, 3);
    base      = RAW_W'($urandom());
    for (int unsigned i = 1; i <= count; i++) begin
      case (raw_mode) inside
        [0:1]: raw = RAW_W'($urandom());
        2: raw = base ^ RAW_W'($urandom_range(0, 255));
        default: begin
          case ($urandom_range(0, 2))
            0: raw = '0;
            1: raw = '1;
            default: raw = RAW_W'($urandom());
          endcase
        end
      endcase
      if (i == pause_at) hold_until_drained();
      send_sample(raw);
    end
    settle();
  endtask

  initial begin
    in_if.valid      = 1'b0;
    in_if.raw_sample = '0;
    cfg_if.valid     = 1'b0;
    cfg_if.index     = '0;
    cfg_if.data      = '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    gaps_on   = 1'b1;
    stalls_on = 1'b1;

    // Reset settings: identity calibration, window of five, all sums normal.
    send_sample(16'h0000);
    send_sample(16'hFFFF);
    send_sample(16'h5555);
    send_sample(16'hAAAA);
    send_sample(16'h00FF);
    send_sample(16'hFF00);
    settle();

    // Largest gain and offset saturate high; a zero length acts as one.
    set_gain(65535);
    set_offset(32767);
    set_length(0);
    set_limits(0, 0);
    end_writes();
    send_sample(16'hFFFF);
    send_sample(16'h0000);
    settle();

    // Most negative offset clamps at zero; crossed limits class the sum low.
    set_gain(0);
    set_offset(-32768);
    set_length(1);
    set_limits(SUM_MAX, 0);
    end_writes();
    send_sample(16'hFFFF);
    send_sample(16'h3039);
    settle();

    // Sums landing exactly on the limits stay normal.
    set_gain(256);
    set_offset(0);
    set_length(2);
    set_limits(100, 200);
    end_writes();
    send_sample(16'd50);
    send_sample(16'd50);
    send_sample(16'd150);
    send_sample(16'd151);
    send_sample(16'd0);
    send_sample(16'd0);
    send_sample(16'd99);
    settle();

    // Full gain with negative offset: saturation at both ends of the calibrated range.
    set_gain(65535);
    set_offset(-32768);
    set_length(3);
    end_writes();
    send_sample(16'hFFFF);
    send_sample(16'h0100);
    send_sample(16'h0001);
    settle();

    run_phase(1'b1, 1'b0);
    while (samples_sent < SAMPLE_GOAL)
      run_phase(1'b0, samples_sent + CALM_SAMPLES >= SAMPLE_GOAL);

    stalls_on = 1'b0;
    gaps_on   = 1'b0;
    settle();
    if (errors == 0 && pending == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
